>>> src/zcrv_pkg.sv
// ----------------------------------------------------------------------------
// zcrv_pkg
// Types and constants shared by the zero-cross release amplifier modules.
// ----------------------------------------------------------------------------
package zcrv_pkg;

	// Command codes of an input item
	localparam logic [1:0] CMD_SAMPLE   = 2'd0;
	localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
	localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_AMP_MAX    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_DECAY      = 3'd1;
	localparam logic [CFG_IW-1:0] REG_FLOOR      = 3'd2;
	localparam logic [CFG_IW-1:0] REG_ZERO_CROSS = 3'd3;
	localparam logic [CFG_IW-1:0] REG_HOLD_LIMIT = 3'd4;

	// Register reset values
	localparam logic [23:0] AMP_MAX_RST    = 24'd8388608;
	localparam logic [23:0] DECAY_RST      = 24'd16249232;
	localparam logic [23:0] FLOOR_RST      = 24'd84;
	localparam logic [14:0] ZERO_CROSS_RST = 15'd82;
	localparam logic [15:0] HOLD_LIMIT_RST = 16'd48;

	// Unity gain in Q1.23
	localparam logic [23:0] GAIN_ONE = 24'd8388608;

	// Divide by 127: floor(x / 127) == (x * DIV127_MUL) >> DIV127_SHIFT for x < 2^31
	localparam logic [31:0] DIV127_MUL   = 32'd2164392969;
	localparam int unsigned DIV127_SHIFT = 38;

	// Depth of the queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW    = 1;
	localparam int unsigned QCW    = 2;

	// Input item
	typedef struct packed {
		logic [1:0]         command;
		logic [2:0]         voice;
		logic [6:0]         velocity;
		logic signed [15:0] sample_in;
		logic               block_end;
	} item_t;

	// Result item
	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               voice_active;
	} result_t;

	// Operation decided by the front
	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_PASS,
		OP_NOTE_ON,
		OP_NOTE_OFF
	} op_t;

	// Queue entry between front and back
	typedef struct packed {
		op_t                op;
		logic [2:0]         voice;
		logic [23:0]        target;
		logic signed [15:0] sample;
		logic               block_end;
	} job_t;

	// Registers used by the back
	typedef struct packed {
		logic [23:0] decay_factor;
		logic [23:0] gain_floor;
		logic [14:0] zero_cross_level;
		logic [15:0] hold_limit;
	} cfg_t;

	// Back sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_DECAY,
		B_SCALE,
		B_OUT
	} bstate_t;

endpackage

>>> src/zcrv_front.sv
// ----------------------------------------------------------------------------
// zcrv_front
// Accepts input items, drops ignored ones, decodes the operation and computes
// the note-on target gain amp_max*velocity/127 in a three-stage pipeline.
// ----------------------------------------------------------------------------
module zcrv_front #(
	parameter int VOICES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  zcrv_pkg::item_t item,
	input  logic [23:0]    amp_max,
	output zcrv_pkg::job_t job,
	output logic           job_push,
	input  logic           job_full
);
	import zcrv_pkg::*;

	logic        valid_s1, valid_s2, valid_s3;
	item_t       item_s1;
	logic        adv;
	logic        keep;
	logic        in_range;
	op_t         op;
	op_t         op_s2, op_s3;
	logic [2:0]  voice_s2, voice_s3;
	logic signed [15:0] sample_s2, sample_s3;
	logic        bend_s2, bend_s3;
	logic [30:0] prod_s2;
	logic [62:0] quo_s3;
	logic [23:0] target;

	// Whole pipeline moves unless the last stage is blocked by the queue
	assign adv  = !valid_s3 || !job_full;
	assign full = valid_s1 && !adv;

	// Classify the item in stage 1
	assign in_range = 32'(item_s1.voice) < VOICES;

	always_comb begin
		keep = 1'b0;
		op   = OP_PASS;
		unique case (item_s1.command)
			CMD_SAMPLE: begin
				keep = 1'b1;
				op   = in_range ? OP_SAMPLE : OP_PASS;
			end
			CMD_NOTE_ON: begin
				keep = in_range;
				op   = (item_s1.velocity != 7'd0) ? OP_NOTE_ON : OP_NOTE_OFF;
			end
			CMD_NOTE_OFF: begin
				keep = in_range;
				op   = OP_NOTE_OFF;
			end
			default: begin
				keep = 1'b0;
				op   = OP_PASS;
			end
		endcase
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (!full)
				valid_s1 <= push;
			if (adv) begin
				valid_s2 <= valid_s1 && keep;
				valid_s3 <= valid_s2;
			end
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (!full)
			item_s1 <= item;
		if (adv) begin
			op_s2     <= op;
			voice_s2  <= item_s1.voice;
			sample_s2 <= item_s1.sample_in;
			bend_s2   <= item_s1.block_end;
			prod_s2   <= 31'(amp_max) * 31'(item_s1.velocity);
			op_s3     <= op_s2;
			voice_s3  <= voice_s2;
			sample_s3 <= sample_s2;
			bend_s3   <= bend_s2;
			quo_s3    <= 63'(prod_s2) * 63'(DIV127_MUL);
		end
	end

	// Saturate the target gain at unity
	always_comb begin
		target = quo_s3[DIV127_SHIFT+23:DIV127_SHIFT];
		if (target > GAIN_ONE)
			target = GAIN_ONE;
	end

	assign job_push      = valid_s3 && !job_full;
	assign job.op        = op_s3;
	assign job.voice     = voice_s3;
	assign job.target    = target;
	assign job.sample    = sample_s3;
	assign job.block_end = bend_s3;

	// A stalled stage 3 keeps its item
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && job_full) |=> valid_s3)
		else $error("front stage 3 lost an item while stalled");

	// Input is refused only while stage 1 holds an item
	a_full_s1: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> valid_s1)
		else $error("front full without a held item");

	// Only kept items reach the queue
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && !keep) |=> !valid_s2)
		else $error("ignored item entered stage 2");

endmodule

>>> src/zcrv_queue.sv
// ----------------------------------------------------------------------------
// zcrv_queue
// Short queue of decoded jobs between front and back.
// ----------------------------------------------------------------------------
module zcrv_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  zcrv_pkg::job_t wr_data,
	output logic           full,
	input  logic           pop,
	output zcrv_pkg::job_t rd_data,
	output logic           empty
);
	import zcrv_pkg::*;

	job_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_push, do_pop;

	assign full    = count_q == QCW'(QDEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("queue count beyond depth");

	a_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == QCW'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("queue empty after a push");

endmodule

>>> src/zcrv_back.sv
// ----------------------------------------------------------------------------
// zcrv_back
// Per-voice state and the sequencer that applies notes and scales samples:
// decode and state update, optional release decay, sample scaling, result.
// ----------------------------------------------------------------------------
module zcrv_back #(
	parameter int VOICES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  zcrv_pkg::job_t   job,
	input  logic             job_empty,
	output logic             job_pop,
	input  zcrv_pkg::cfg_t   cfg,
	output logic             empty,
	input  logic             pop,
	output zcrv_pkg::result_t result
);
	import zcrv_pkg::*;

	// Only eight voices are addressable by the item
	localparam int NV = (VOICES < 8) ? VOICES : 8;
	localparam int VW = (NV > 1) ? $clog2(NV) : 1;

	bstate_t state_q, state_d;

	logic        active_q    [NV];
	logic        gate_q      [NV];
	logic        releasing_q [NV];
	logic [15:0] hold_q      [NV];
	logic [23:0] gain_q      [NV];
	logic [23:0] target_q    [NV];

	logic [VW-1:0]       v, vx_q;
	logic signed [15:0]  sample_q;
	logic                bend_q;
	logic [23:0]         gain_w_q;
	logic                res_act_q;
	logic [47:0]         dprod_q;
	logic signed [40:0]  sprod_q;
	logic                out_valid_q;
	result_t             out_q;

	logic [16:0] s17, mag;
	logic [15:0] hold_inc, hold_next;
	logic        rel_new, live, go_decay, go_scale, go_out, idle_kill;
	logic [23:0] dec_g;
	logic        dec_kill;
	logic        out_load;

	// Decode the head job against its voice state
	assign v = job.voice[VW-1:0];

	always_comb begin
		s17       = {job.sample[15], job.sample};
		mag       = s17[16] ? 17'(-s17) : s17;
		hold_inc  = (hold_q[v] == 16'hFFFF) ? hold_q[v] : hold_q[v] + 16'd1;
		hold_next = releasing_q[v] ? hold_q[v] : hold_inc;
		rel_new   = releasing_q[v] || (mag <= {2'b00, cfg.zero_cross_level})
		            || (hold_inc >= cfg.hold_limit);
		live      = (job.op == OP_SAMPLE) && active_q[v];
		go_decay  = live && !gate_q[v] && rel_new;
		go_scale  = live && (gate_q[v] || !rel_new);
		go_out    = (job.op == OP_PASS) || ((job.op == OP_SAMPLE) && !active_q[v]);
		idle_kill = job.block_end && (gain_q[v] == '0);
	end

	// Decayed gain with floor
	always_comb begin
		dec_g = dprod_q[47:24];
		if (dec_g < cfg.gain_floor)
			dec_g = '0;
		dec_kill = bend_q && (dec_g == '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!job_empty) begin
					if (go_decay)
						state_d = B_DECAY;
					else if (go_scale)
						state_d = B_SCALE;
					else if (go_out)
						state_d = B_OUT;
				end
			end
			B_DECAY: state_d = B_SCALE;
			B_SCALE: state_d = B_OUT;
			B_OUT: begin
				if (!out_valid_q || pop)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		job_pop  = (state_q == B_IDLE) && !job_empty;
		out_load = (state_q == B_OUT) && (!out_valid_q || pop);
	end

	// Control state and per-voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NV; i++) begin
				active_q[i]    <= 1'b0;
				gate_q[i]      <= 1'b0;
				releasing_q[i] <= 1'b0;
				hold_q[i]      <= '0;
				gain_q[i]      <= '0;
				target_q[i]    <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;

			if (job_pop) begin
				case (job.op)
					OP_NOTE_ON: begin
						active_q[v]    <= 1'b1;
						gate_q[v]      <= 1'b1;
						releasing_q[v] <= 1'b0;
						hold_q[v]      <= '0;
						target_q[v]    <= job.target;
						gain_q[v]      <= job.target;
					end
					OP_NOTE_OFF: begin
						if (active_q[v]) begin
							gate_q[v]      <= 1'b0;
							releasing_q[v] <= 1'b0;
							hold_q[v]      <= '0;
						end
					end
					default: begin
						if (live) begin
							if (gate_q[v]) begin
								gain_q[v] <= target_q[v];
							end else begin
								hold_q[v]      <= hold_next;
								releasing_q[v] <= rel_new;
								if (!rel_new && idle_kill)
									active_q[v] <= 1'b0;
							end
						end
					end
				endcase
			end

			// Write back the decayed gain
			if (state_q == B_DECAY) begin
				gain_q[vx_q] <= dec_g;
				if (dec_kill)
					active_q[vx_q] <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			vx_q     <= v;
			sample_q <= job.sample;
			bend_q   <= job.block_end;
			dprod_q  <= 48'(gain_q[v]) * 48'(cfg.decay_factor);
			// Pass-through: unity-scaled copy of the sample
			if (go_out) begin
				sprod_q   <= 41'(job.sample) <<< 23;
				res_act_q <= 1'b0;
			end else if (gate_q[v]) begin
				gain_w_q  <= target_q[v];
				res_act_q <= 1'b1;
			end else begin
				gain_w_q  <= gain_q[v];
				res_act_q <= !idle_kill;
			end
		end
		if (state_q == B_DECAY) begin
			gain_w_q  <= dec_g;
			res_act_q <= !dec_kill;
		end
		if (state_q == B_SCALE)
			sprod_q <= 41'(sample_q) * 41'($signed({1'b0, gain_w_q}));
		if (out_load) begin
			out_q.sample_out   <= sprod_q[38:23];
			out_q.voice_active <= res_act_q;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	// A waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT && out_valid_q && !pop) |=> (state_q == B_OUT))
		else $error("result register overwritten");

	// Decay step is always followed by scaling
	a_decay_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DECAY) |=> (state_q == B_SCALE))
		else $error("decay not followed by scale");

	// Jobs are taken only in idle with a job waiting
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> (!job_empty && state_q == B_IDLE))
		else $error("job taken outside idle");

endmodule

>>> src/zero_cross_release_vca.sv
// ----------------------------------------------------------------------------
// zero_cross_release_vca
// Multi-voice amplifier with zero-cross release. Items enter through a queue
// style port (push/full) and results leave through one (empty/pop); only
// sample items give a result. Each accepted item goes through a three-stage
// front pipeline that drops ignored items and computes the note-on gain, then
// through a two-entry job queue to the back sequencer. In the back a note is
// applied in idle, a passed-through sample goes straight to output, a held
// voice's sample is scaled, and a sample of a voice in release is decayed and
// then scaled before it lands in the result register; a voice's state update
// finishes before the next job is taken, so the back sets the sustained rate.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// the user must write it only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module zero_cross_release_vca #(
	parameter int VOICES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  zcrv_pkg::item_t                   item,
	output logic                              empty,
	input  logic                              pop,
	output zcrv_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [zcrv_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [23:0]                       cfg_data
);
	import zcrv_pkg::*;

	logic [23:0] amp_max_q;
	cfg_t        cfg_q;
	job_t        fr_job, q_job;
	logic        fr_push, q_full, q_pop, q_empty;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_max_q              <= AMP_MAX_RST;
			cfg_q.decay_factor     <= DECAY_RST;
			cfg_q.gain_floor       <= FLOOR_RST;
			cfg_q.zero_cross_level <= ZERO_CROSS_RST;
			cfg_q.hold_limit       <= HOLD_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_AMP_MAX:    amp_max_q              <= cfg_data;
				REG_DECAY:      cfg_q.decay_factor     <= cfg_data;
				REG_FLOOR:      cfg_q.gain_floor       <= cfg_data;
				REG_ZERO_CROSS: cfg_q.zero_cross_level <= cfg_data[14:0];
				REG_HOLD_LIMIT: cfg_q.hold_limit       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	zcrv_front #(
		.VOICES(VOICES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.amp_max  (amp_max_q),
		.job      (fr_job),
		.job_push (fr_push),
		.job_full (q_full)
	);

	zcrv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fr_push),
		.wr_data (fr_job),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_job),
		.empty   (q_empty)
	);

	zcrv_back #(
		.VOICES(VOICES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_job),
		.job_empty (q_empty),
		.job_pop   (q_pop),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

>>> verif/zero_cross_release_vca_tb.sv
// ----------------------------------------------------------------------------
// zero_cross_release_vca_tb
// Self-checking bench for the multi-voice zero-cross release amplifier. An
// in-bench voice model tracks gate, hold and release per voice and predicts
// the scaled sample and voice state for every sample beat. Directed cases
// cover the edges of each field and the release corner cases. Random phases
// then run under several register settings. Both ports idle at random, and
// one phase holds off the result side until the input side stalls.
// ----------------------------------------------------------------------------
module zero_cross_release_vca_tb;
	import zcrv_pkg::*;

	localparam int VOICES       = 8;
	localparam int DRAIN_CYCLES = 32;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	item_t             item = '0;
	logic              empty;
	logic              pop = 1'b0;
	result_t           result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [23:0]       cfg_data = '0;

	// Register copies used for prediction
	logic [23:0] cfg_amp_max    = AMP_MAX_RST;
	logic [23:0] cfg_decay      = DECAY_RST;
	logic [23:0] cfg_floor      = FLOOR_RST;
	logic [14:0] cfg_zero_cross = ZERO_CROSS_RST;
	logic [15:0] cfg_hold_limit = HOLD_LIMIT_RST;

	// Per-voice state of the amplifier
	bit          voice_on     [VOICES];
	bit          voice_gate   [VOICES];
	bit          voice_rel    [VOICES];
	logic [15:0] hold_cnt     [VOICES];
	logic [23:0] voice_gain   [VOICES];
	logic [23:0] voice_target [VOICES];

	result_t pending_outputs [$];
	int      errors      = 0;
	int      burst_left  = 0;
	bit      tx_gaps     = 1'b1;
	int      rx_hold_req = 0;

	zero_cross_release_vca #(.VOICES(VOICES)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one item to the voice model; return 1 with the scaled sample if it gives one
	function automatic bit amplify_item(input item_t it, output result_t res);
		logic [63:0] wide;
		logic [23:0] g;
		longint      scaled;
		int          v;
		int          mag;
		v = it.voice;
		res = '0;
		if (it.command == CMD_UNUSED)
			return 1'b0;
		if (it.command == CMD_NOTE_ON || it.command == CMD_NOTE_OFF) begin
			if (v >= VOICES)
				return 1'b0;
			if (it.command == CMD_NOTE_ON && it.velocity != 0) begin
				wide = (64'(cfg_amp_max) * 64'(it.velocity)) / 64'd127;
				if (wide > 64'(GAIN_ONE))
					wide = 64'(GAIN_ONE);
				voice_on[v]     = 1'b1;
				voice_gate[v]   = 1'b1;
				voice_rel[v]    = 1'b0;
				hold_cnt[v]     = '0;
				voice_target[v] = wide[23:0];
				voice_gain[v]   = wide[23:0];
			end else if (voice_on[v]) begin
				voice_gate[v] = 1'b0;
				voice_rel[v]  = 1'b0;
				hold_cnt[v]   = '0;
			end
			return 1'b0;
		end
		// sample beat: inactive voices pass straight through
		if (v >= VOICES || !voice_on[v]) begin
			res.sample_out   = it.sample_in;
			res.voice_active = 1'b0;
			return 1'b1;
		end
		if (voice_gate[v]) begin
			voice_gain[v] = voice_target[v];
			g = voice_gain[v];
		end else begin
			g = voice_gain[v];
			// hold until a zero crossing or the hold limit
			if (!voice_rel[v]) begin
				mag = $signed(it.sample_in);
				if (mag < 0)
					mag = -mag;
				if (hold_cnt[v] != 16'hFFFF)
					hold_cnt[v] = hold_cnt[v] + 16'd1;
				if (mag <= int'(cfg_zero_cross) || hold_cnt[v] >= cfg_hold_limit)
					voice_rel[v] = 1'b1;
			end
			if (voice_rel[v]) begin
				wide = (64'(g) * 64'(cfg_decay)) >> 24;
				g = wide[23:0];
				if (g < cfg_floor)
					g = '0;
			end
			voice_gain[v] = g;
			if (it.block_end && g == 0)
				voice_on[v] = 1'b0;
		end
		scaled = (longint'($signed(it.sample_in)) * longint'({1'b0, g})) >>> 23;
		res.sample_out   = scaled[15:0];
		res.voice_active = voice_on[v];
		return 1'b1;
	endfunction

	function automatic item_t mk(input logic [1:0] cmd, input int v, input int vel,
			input logic signed [15:0] s, input bit be);
		item_t it;
		it.command   = cmd;
		it.voice     = 3'(v);
		it.velocity  = 7'(vel);
		it.sample_in = s;
		it.block_end = be;
		return it;
	endfunction

	// Mix of near-zero, full-scale and uniform samples
	function automatic logic [15:0] rand_sample();
		int span;
		int r;
		span = int'(cfg_zero_cross) + 1;
		case ($urandom_range(0, 5))
			0, 1: r = int'($urandom_range(0, 2 * span)) - span;
			2: begin
				case ($urandom_range(0, 3))
					0: r = -32768;
					1: r = 32767;
					2: r = 0;
					default: r = -1;
				endcase
			end
			default: r = int'($urandom_range(0, 65535));
		endcase
		return r[15:0];
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int    pick;
		it.voice     = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
		it.velocity  = 7'($urandom_range(0, 127));
		it.sample_in = rand_sample();
		it.block_end = ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			it.command = CMD_NOTE_ON;
			if ($urandom_range(0, 9) == 0)
				it.velocity = '0;
		end else if (pick < 20) begin
			it.command = CMD_NOTE_OFF;
		end else if (pick < 23) begin
			it.command = CMD_UNUSED;
		end else begin
			it.command = CMD_SAMPLE;
		end
		return it;
	endfunction

	// Offer one beat in bursts, with random gaps while tx_gaps is set; predict once it is taken
	task automatic push_item(input item_t it);
		result_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (tx_gaps) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		burst_left--;
		if (amplify_item(it, res))
			pending_outputs.push_back(res);
	endtask

	// Stop sending and wait for every expected beat plus the pipeline tail
	task automatic settle();
		push <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [23:0] am, input logic [23:0] df,
			input logic [23:0] fl, input logic [14:0] zc, input logic [15:0] hl);
		logic [CFG_IW-1:0] regs [5] = '{REG_AMP_MAX, REG_DECAY, REG_FLOOR,
			REG_ZERO_CROSS, REG_HOLD_LIMIT};
		logic [23:0] vals [5];
		vals[0] = am;
		vals[1] = df;
		vals[2] = fl;
		vals[3] = {9'd0, zc};
		vals[4] = {8'd0, hl};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_amp_max    = am;
		cfg_decay      = df;
		cfg_floor      = fl;
		cfg_zero_cross = zc;
		cfg_hold_limit = hl;
	endtask

	// Field extremes and note handling under reset settings
	task automatic test_directed();
		push_item(mk(CMD_SAMPLE, 0, 0, 16'sh7FFF, 1'b0));
		push_item(mk(CMD_UNUSED, 1, 127, 16'sh1234, 1'b1));
		push_item(mk(CMD_NOTE_OFF, 2, 0, 16'sh0000, 1'b0));
		push_item(mk(CMD_NOTE_ON, 0, 127, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 0, 0, 16'sh7FFF, 1'b0));
		push_item(mk(CMD_SAMPLE, 0, 0, 16'sh8000, 1'b0));
		push_item(mk(CMD_SAMPLE, 0, 0, 16'sh0000, 1'b1));
		push_item(mk(CMD_NOTE_ON, 1, 1, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 1, 0, 16'shFFFF, 1'b0));
		push_item(mk(CMD_SAMPLE, 1, 0, 16'sh7FFF, 1'b1));
		push_item(mk(CMD_NOTE_ON, 2, 0, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 2, 0, 16'sh4000, 1'b0));
		push_item(mk(CMD_NOTE_OFF, 0, 0, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 0, 0, 16'sh03E8, 1'b0));
		push_item(mk(CMD_SAMPLE, 0, 0, 16'shFFB0, 1'b0));
		push_item(mk(CMD_SAMPLE, 0, 0, 16'sh8000, 1'b1));
		push_item(mk(CMD_NOTE_ON, 3, 64, 16'sh0000, 1'b0));
		push_item(mk(CMD_NOTE_ON, 3, 0, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 3, 0, 16'shFF9C, 1'b1));
		push_item(mk(CMD_SAMPLE, 7, 0, 16'sh5555, 1'b1));
		settle();
	endtask

	// Saturated target, instant release, zero gain while gated
	task automatic test_release_extremes();
		set_config(24'hFFFFFF, 24'd0, 24'd0, 15'd0, 16'd0);
		push_item(mk(CMD_NOTE_ON, 4, 127, 16'sh0000, 1'b0));
		push_item(mk(CMD_NOTE_ON, 6, 64, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 4, 0, 16'sh7FFF, 1'b0));
		push_item(mk(CMD_SAMPLE, 6, 0, 16'sh8000, 1'b0));
		push_item(mk(CMD_NOTE_OFF, 4, 0, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 4, 0, 16'sh4E20, 1'b0));
		push_item(mk(CMD_SAMPLE, 4, 0, 16'shFFFB, 1'b1));
		push_item(mk(CMD_SAMPLE, 4, 0, 16'sh2222, 1'b0));
		settle();
		set_config(24'd0, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF, 16'hFFFF);
		push_item(mk(CMD_NOTE_ON, 5, 100, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 5, 0, 16'sh7FFF, 1'b1));
		push_item(mk(CMD_NOTE_OFF, 5, 0, 16'sh0000, 1'b0));
		push_item(mk(CMD_SAMPLE, 5, 0, 16'sh0000, 1'b1));
		push_item(mk(CMD_SAMPLE, 5, 0, 16'sh7FFF, 1'b0));
		settle();
	endtask

	task automatic run_phase(input logic [23:0] am, input logic [23:0] df,
			input logic [23:0] fl, input logic [14:0] zc, input logic [15:0] hl, input int n);
		set_config(am, df, fl, zc, hl);
		repeat (n) push_item(rand_item());
		settle();
	endtask

	// Random traffic under a sweep of register settings
	task automatic test_random_settings();
		run_phase(GAIN_ONE, 24'd12582912, 24'd4096, ZERO_CROSS_RST, 16'd8, 70);
		run_phase(24'hFFFFFF, 24'd8388608, FLOOR_RST, 15'h7FFF, 16'd1, 70);
		run_phase(24'd0, 24'hFFFFFF, 24'd0, 15'd0, 16'hFFFF, 60);
		run_phase(24'd4194304, 24'd0, GAIN_ONE, 15'd1000, 16'd0, 60);
		run_phase(24'($urandom), 24'($urandom_range(8388608, 16777215)),
			24'($urandom_range(0, 65535)), 15'($urandom), 16'($urandom_range(1, 20)), 70);
		run_phase(GAIN_ONE, 24'd15000000, 24'hFFFFFF, 15'd200, 16'd4, 50);
		run_phase(AMP_MAX_RST, DECAY_RST, FLOOR_RST, ZERO_CROSS_RST, HOLD_LIMIT_RST, 40);
	endtask

	// Hold off results until the input side stalls, sending without gaps
	task automatic test_backpressure();
		item_t it;
		set_config(GAIN_ONE, 24'd12582912, 24'd4096, 15'd200, 16'd16);
		tx_gaps    = 1'b0;
		burst_left = 0;
		rx_hold_req = 300;
		for (int v = 0; v < 4; v++)
			push_item(mk(CMD_NOTE_ON, v, 90 + v, 16'sh0000, 1'b0));
		repeat (36) begin
			it = rand_item();
			it.command = CMD_SAMPLE;
			push_item(it);
		end
		tx_gaps = 1'b1;
		settle();
	endtask

	initial begin : sequencer
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_release_extremes();
		test_random_settings();
		test_backpressure();
		settle();
		if (errors == 0)
			$display("zero_cross_release_vca regression: pass");
		else
			$display("zero_cross_release_vca regression: fail");
		$finish;
	end

	// Check each popped beat and pick the next stall pattern
	initial begin : output_check
		result_t want;
		int      seg_left;
		int      mode;
		int      cyc;
		int      hold_left;
		seg_left  = 0;
		mode      = 0;
		cyc       = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_outputs.size() == 0) begin
					$display("%0t: unexpected beat, got sample_out %0d voice_active %0b",
						$time, result.sample_out, result.voice_active);
					errors++;
				end else begin
					want = pending_outputs.pop_front();
					if (result.sample_out !== want.sample_out) begin
						$display("%0t: sample_out expected %0d got %0d",
							$time, want.sample_out, result.sample_out);
						errors++;
					end
					if (result.voice_active !== want.voice_active) begin
						$display("%0t: voice_active expected %0b got %0b",
							$time, want.voice_active, result.voice_active);
						errors++;
					end
				end
			end
			cyc++;
			if (rx_hold_req != 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (seg_left == 0) begin
				mode     = $urandom_range(0, 3);
				seg_left = $urandom_range(16, 80);
			end
			seg_left--;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= (cyc % 3 != 0);
				endcase
			end
		end
	end

	// Watchdog
	initial begin : run_limit
		#3000000;
		$display("zero_cross_release_vca regression: fail");
		$finish;
	end

endmodule
